@@ design/frame_atomic_tx_ring_queue_unit_assert.svh @@
// assertion macros for the transmit ring queue checker
// no dependencies; taken in by the checker file with an include
`ifndef FRAME_ATOMIC_TX_RING_QUEUE_UNIT_ASSERT_SVH
`define FRAME_ATOMIC_TX_RING_QUEUE_UNIT_ASSERT_SVH

// checked while out of reset
`define FTXQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FTXQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ftxq_pkg.sv @@
// shared types and codes of the transmit ring queue
// no dependencies; used by every module of the block but ftxq_ram
package ftxq_pkg;

	// command codes
	localparam logic [1:0] CMD_OFFER = 2'd0;
	localparam logic [1:0] CMD_WORD  = 2'd1;
	localparam logic [1:0] CMD_DRAIN = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_OFFER = 2'd0;
	localparam logic [1:0] KIND_BYTE  = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	// offer status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_BAD_LEN = 2'd1;
	localparam logic [1:0] STAT_NO_ROOM = 2'd2;

	localparam int LEVEL_W = 5;

	typedef struct packed {
		logic [1:0]         command;
		logic [15:0]        frame_length;
		logic [15:0]        frame_word;
		logic [LEVEL_W-1:0] fifo_level;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [7:0]  tx_byte;
		logic        irq_enable;
		logic [31:0] drop_count;
		logic [7:0]  free_slots;
		logic        last;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CHECK,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic offer;
		logic word;
		logic read;
		logic emit_byte;
		logic emit_done;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] command;
		logic       brem_zero;
		logic       brem_one;
		logic       drain_more;
		logic       out_free;
	} dp_stat_t;

endpackage

@@ design/frame_atomic_tx_ring_queue_unit.sv @@
// top level of the frame-atomic transmit ring queue
// an item is captured, then run: an offer registers its status, a data word stores one byte
// a drain (command or final frame byte) reads each byte from the byte store port and emits it,
// then the finished transaction; output stalls hold each step, ready returns after the last result
// reset clears pointers, open frame, drop counter and result valid; store contents are undefined
// depends on ftxq_pkg, ftxq_ctrl, ftxq_dp, ftxq_ram
module frame_atomic_tx_ring_queue_unit #(
	parameter int QUEUE_DEPTH   = 256,
	parameter int HW_FIFO_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  ftxq_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output ftxq_pkg::out_item_t result
);

	// command and status between controller and datapath
	ftxq_pkg::ctrl_cmd_t cmd;
	ftxq_pkg::dp_stat_t  stat;

	// controller: one transaction in flight, sequences offer, word and drain steps
	ftxq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// datapath: ring pointers, frame counters, byte store and the result register
	ftxq_dp #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.HW_FIFO_DEPTH (HW_FIFO_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

@@ design/ftxq_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
module ftxq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/ftxq_ctrl.sv @@
// controller state machine of the transmit ring queue
// depends on ftxq_pkg
module ftxq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  ftxq_pkg::dp_stat_t   stat,
	output ftxq_pkg::ctrl_cmd_t  cmd
);

	ftxq_pkg::state_t state_q;
	ftxq_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ftxq_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ftxq_pkg::ST_IDLE: begin
				if (item_valid) state_next = ftxq_pkg::ST_EXEC;
			end
			ftxq_pkg::ST_EXEC: begin
				unique case (stat.command)
					ftxq_pkg::CMD_OFFER: begin
						if (stat.out_free) state_next = ftxq_pkg::ST_IDLE;
					end
					ftxq_pkg::CMD_WORD: begin
						if (!stat.brem_zero && stat.brem_one) state_next = ftxq_pkg::ST_CHECK;
						else state_next = ftxq_pkg::ST_IDLE;
					end
					ftxq_pkg::CMD_DRAIN: state_next = ftxq_pkg::ST_CHECK;
					default: state_next = ftxq_pkg::ST_IDLE;
				endcase
			end
			ftxq_pkg::ST_CHECK: begin
				if (stat.drain_more) state_next = ftxq_pkg::ST_EMIT;
				else if (stat.out_free) state_next = ftxq_pkg::ST_IDLE;
			end
			ftxq_pkg::ST_EMIT: begin
				if (stat.out_free) state_next = ftxq_pkg::ST_CHECK;
			end
			default: state_next = ftxq_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_ready = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ftxq_pkg::ST_IDLE: begin
				item_ready  = 1'b1;
				cmd.capture = item_valid;
			end
			ftxq_pkg::ST_EXEC: begin
				if (stat.command == ftxq_pkg::CMD_OFFER) cmd.offer = stat.out_free;
				if (stat.command == ftxq_pkg::CMD_WORD) cmd.word = !stat.brem_zero;
			end
			ftxq_pkg::ST_CHECK: begin
				cmd.read      = stat.drain_more;
				cmd.emit_done = !stat.drain_more && stat.out_free;
			end
			ftxq_pkg::ST_EMIT: begin
				cmd.emit_byte = stat.out_free;
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

endmodule

@@ design/ftxq_dp.sv @@
// datapath of the transmit ring queue: pointers, counters, byte store, result register
// depends on ftxq_pkg and ftxq_ram
module ftxq_dp #(
	parameter int QUEUE_DEPTH   = 256,
	parameter int HW_FIFO_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ftxq_pkg::in_item_t   item,
	input  ftxq_pkg::ctrl_cmd_t  cmd,
	output ftxq_pkg::dp_stat_t   stat,
	output logic                 result_valid,
	input  logic                 result_ready,
	output ftxq_pkg::out_item_t  result
);

	localparam int PW  = $clog2(QUEUE_DEPTH);
	localparam int UW  = PW + 1;
	localparam int HLW = $clog2(HW_FIFO_DEPTH + 1);
	localparam int LW  = (HLW > ftxq_pkg::LEVEL_W) ? HLW : ftxq_pkg::LEVEL_W;
	localparam logic [PW-1:0] LAST_IDX = PW'(QUEUE_DEPTH - 1);
	localparam logic [UW-1:0] DEPTH_U  = UW'(QUEUE_DEPTH);
	localparam logic [16:0]   DEPTH_L  = 17'(QUEUE_DEPTH);
	localparam logic [LW-1:0] HW_LVL   = LW'(HW_FIFO_DEPTH);

	ftxq_pkg::in_item_t  item_q;
	ftxq_pkg::out_item_t result_q;
	ftxq_pkg::out_item_t result_next;
	logic                result_valid_q;

	logic [PW-1:0] rp_q, cwp_q, wwp_q, brem_q;
	logic [LW-1:0] level_q;
	logic [31:0]   drop_q;

	logic [PW-1:0] rp_inc, wwp_inc;
	logic [UW-1:0] used_raw, used, free_w;
	logic          len_bad, no_room, out_free;
	logic [7:0]    rd_byte;

	assign rp_inc  = (rp_q == LAST_IDX) ? '0 : rp_q + 1'b1;
	assign wwp_inc = (wwp_q == LAST_IDX) ? '0 : wwp_q + 1'b1;

	// occupancy of committed data, modulo the depth
	assign used_raw = {1'b0, cwp_q} - {1'b0, rp_q};
	assign used     = (cwp_q >= rp_q) ? used_raw : used_raw + DEPTH_U;
	assign free_w   = (DEPTH_U - 1'b1) - used;

	assign len_bad = (item_q.frame_length == '0) || ({1'b0, item_q.frame_length} >= DEPTH_L);
	assign no_room = {1'b0, item_q.frame_length} > 17'(free_w);

	assign out_free = !result_valid_q || result_ready;

	assign stat.command    = item_q.command;
	assign stat.brem_zero  = (brem_q == '0);
	assign stat.brem_one   = (brem_q == PW'(1));
	assign stat.drain_more = (rp_q != cwp_q) && (level_q < HW_LVL);
	assign stat.out_free   = out_free;

	ftxq_ram #(
		.WIDTH(8),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (cmd.word),
		.wr_addr (wwp_q),
		.wr_data (item_q.frame_word[7:0]),
		.rd_en   (cmd.read),
		.rd_addr (rp_q),
		.rd_data (rd_byte)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q    <= '0;
			cwp_q   <= '0;
			wwp_q   <= '0;
			brem_q  <= '0;
			drop_q  <= '0;
			level_q <= '0;
		end else begin
			if (cmd.capture) begin
				level_q <= LW'(item.fifo_level);
			end
			if (cmd.offer) begin
				wwp_q  <= cwp_q;
				brem_q <= (len_bad || no_room) ? '0 : PW'(item_q.frame_length);
				if (!len_bad && no_room) drop_q <= drop_q + 32'd1;
			end
			if (cmd.word) begin
				wwp_q  <= wwp_inc;
				brem_q <= brem_q - 1'b1;
				if (brem_q == PW'(1)) cwp_q <= wwp_inc;
			end
			if (cmd.emit_byte) begin
				rp_q    <= rp_inc;
				level_q <= level_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.offer || cmd.emit_byte || cmd.emit_done) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// next result transaction
	always_comb begin
		result_next            = '0;
		result_next.drop_count = drop_q;
		if (cmd.offer) begin
			result_next.kind = ftxq_pkg::KIND_OFFER;
			result_next.last = 1'b1;
			if (len_bad) begin
				result_next.status = ftxq_pkg::STAT_BAD_LEN;
			end else if (no_room) begin
				result_next.status     = ftxq_pkg::STAT_NO_ROOM;
				result_next.drop_count = drop_q + 32'd1;
				result_next.free_slots = 8'(free_w);
			end else begin
				result_next.status     = ftxq_pkg::STAT_OK;
				result_next.free_slots = 8'(free_w);
			end
		end else if (cmd.emit_byte) begin
			result_next.kind    = ftxq_pkg::KIND_BYTE;
			result_next.tx_byte = rd_byte;
		end else begin
			result_next.kind       = ftxq_pkg::KIND_DONE;
			result_next.irq_enable = (rp_q != cwp_q);
			result_next.last       = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.offer || cmd.emit_byte || cmd.emit_done) begin
			result_q <= result_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

@@ design/ftxq_checker.sv @@
// port-level checker for the transmit ring queue, bound to the top level
// depends on ftxq_pkg and frame_atomic_tx_ring_queue_unit_assert.svh
`include "frame_atomic_tx_ring_queue_unit_assert.svh"

module ftxq_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input ftxq_pkg::in_item_t  item,
	input logic                result_valid,
	input logic                result_ready,
	input ftxq_pkg::out_item_t result
);

	`FTXQ_ASSERT(a_item_hold, clk, arst_n, item_valid && !item_ready |=> item_valid && $stable(item), "input changed while waiting")
	`FTXQ_ASSERT(a_result_hold, clk, arst_n, result_valid && !result_ready |=> result_valid && $stable(result), "result changed while stalled")
	`FTXQ_ASSERT(a_offer_last, clk, arst_n, result_valid && result.kind == ftxq_pkg::KIND_OFFER |-> result.last, "offer status not marked last")
	`FTXQ_ASSERT(a_byte_not_last, clk, arst_n, result_valid && result.kind == ftxq_pkg::KIND_BYTE |-> !result.last && result.status == ftxq_pkg::STAT_OK, "drained byte marked last or with status")
	`FTXQ_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !result_valid, "result valid during reset")

endmodule

bind frame_atomic_tx_ring_queue_unit ftxq_checker u_checker (.*);

@@ tb/sv/frame_atomic_tx_ring_queue_unit_test.sv @@
// self-checking testbench for the frame-atomic transmit ring queue
// drives a directed table and then random frame traffic, checking every result transaction
// against a typed row or its ring model; depends on ftxq_pkg and frame_atomic_tx_ring_queue_unit
module frame_atomic_tx_ring_queue_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDEPTH       = 256;
	localparam int HW_DEPTH     = 16;
	localparam int ITEMS        = 460;
	localparam int LIMIT_CYCLES = 500000;
	localparam int SETTLE       = 40;
	localparam int NUM_DIR      = 21;

	// command code the block does not know, ignored without results
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	logic                clk;
	logic                arst_n;
	logic                item_valid;
	logic                item_ready;
	ftxq_pkg::in_item_t  item;
	logic                result_valid;
	logic                result_ready;
	ftxq_pkg::out_item_t result;

	frame_atomic_tx_ring_queue_unit #(
		.QUEUE_DEPTH  (QDEPTH),
		.HW_FIFO_DEPTH(HW_DEPTH)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	// ring model state, mirrors the block's pointers and counters
	logic [7:0]  ring_bytes [QDEPTH];
	int          rd_ptr;
	int          commit_ptr;
	int          work_ptr;
	int          frame_left;
	logic [31:0] drop_total;

	// results still owed by the block, oldest first
	ftxq_pkg::out_item_t awaited_results [$];

	int          failures;
	int          results_seen;
	int          handled_items;
	int          bytes_drained;
	int          refusals;
	int          cycles;
	int          gap_pct;
	int          stall_pct;

	// one row of the directed table; typed rows carry their own expected result
	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] len;
		logic [15:0] wrd;
		logic [4:0]  lvl;
		logic        typed;
		logic [1:0]  e_kind;
		logic [1:0]  e_status;
		logic        e_irq;
		logic [31:0] e_drops;
		logic [7:0]  e_free;
	} dir_row_t;

	dir_row_t dir_rows [NUM_DIR];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle counter and watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("timeout after %0d cycles, %0d results outstanding",
					cycles, awaited_results.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic int ring_next(input int p);
		return (p + 1 >= QDEPTH) ? 0 : p + 1;
	endfunction

	// drain committed bytes while the hardware fifo has room, then the finished item
	function automatic void forecast_drain(input logic [4:0] level, input bit record);
		int                  lvl;
		ftxq_pkg::out_item_t r;
		lvl = level;
		while (rd_ptr != commit_ptr && lvl < HW_DEPTH) begin
			r            = '0;
			r.kind       = ftxq_pkg::KIND_BYTE;
			r.tx_byte    = ring_bytes[rd_ptr];
			r.drop_count = drop_total;
			if (record)
				awaited_results.push_back(r);
			lvl++;
			rd_ptr = ring_next(rd_ptr);
		end
		r            = '0;
		r.kind       = ftxq_pkg::KIND_DONE;
		r.irq_enable = (rd_ptr != commit_ptr);
		r.drop_count = drop_total;
		r.last       = 1'b1;
		if (record)
			awaited_results.push_back(r);
	endfunction

	// advances the ring model by one transaction; returns 0 when the block ignores it
	function automatic bit forecast_ring(input ftxq_pkg::in_item_t it, input bit record);
		int                  used;
		int                  room;
		bit                  handled;
		ftxq_pkg::out_item_t r;
		handled = 1'b1;
		case (it.command)
			ftxq_pkg::CMD_OFFER: begin
				// any open frame is abandoned before the offer is judged
				frame_left = 0;
				work_ptr   = commit_ptr;
				r          = '0;
				r.kind     = ftxq_pkg::KIND_OFFER;
				r.last     = 1'b1;
				if (it.frame_length == 0 || it.frame_length >= QDEPTH) begin
					r.status = ftxq_pkg::STAT_BAD_LEN;
				end else begin
					used         = (commit_ptr + QDEPTH - rd_ptr) % QDEPTH;
					room         = QDEPTH - 1 - used;
					r.free_slots = room[7:0];
					if (it.frame_length > room) begin
						drop_total = drop_total + 32'd1;
						r.status   = ftxq_pkg::STAT_NO_ROOM;
						refusals++;
					end else begin
						r.status   = ftxq_pkg::STAT_OK;
						frame_left = it.frame_length;
					end
				end
				r.drop_count = drop_total;
				if (record)
					awaited_results.push_back(r);
			end
			ftxq_pkg::CMD_WORD: begin
				if (frame_left == 0) begin
					handled = 1'b0;
				end else begin
					ring_bytes[work_ptr] = it.frame_word[7:0];
					work_ptr             = ring_next(work_ptr);
					frame_left--;
					// final byte commits the frame and drains at once
					if (frame_left == 0) begin
						commit_ptr = work_ptr;
						forecast_drain(it.fifo_level, record);
					end
				end
			end
			ftxq_pkg::CMD_DRAIN: begin
				forecast_drain(it.fifo_level, record);
			end
			default: begin
				handled = 1'b0;
			end
		endcase
		return handled;
	endfunction

	// idling profile follows progress through the run
	task automatic set_phase();
		case (handled_items * 4 / ITEMS)
			0: begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			1: begin
				gap_pct   = 47;
				stall_pct = 0;
			end
			2: begin
				gap_pct   = 0;
				stall_pct = 47;
			end
			default: begin
				gap_pct   = 14;
				stall_pct = 14;
			end
		endcase
	endtask

	// predicts, then offers one transaction and holds it until accepted
	task automatic send_transaction(input ftxq_pkg::in_item_t it, input bit typed,
		input ftxq_pkg::out_item_t typed_res);
		bit handled;
		set_phase();
		handled = forecast_ring(it, !typed);
		if (typed)
			awaited_results.push_back(typed_res);
		if (handled)
			handled_items++;
		while ($urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
	endtask

	task automatic send_cmd(input logic [1:0] cmd, input logic [15:0] len,
		input logic [15:0] wrd, input logic [4:0] lvl);
		ftxq_pkg::in_item_t it;
		it.command      = cmd;
		it.frame_length = len;
		it.frame_word   = wrd;
		it.fifo_level   = lvl;
		send_transaction(it, 1'b0, '0);
	endtask

	// mostly low levels so that drains move many bytes, now and then a full fifo
	function automatic logic [4:0] pick_level();
		int r;
		r = $urandom_range(99);
		if (r < 30)
			return 5'd0;
		else if (r < 75)
			return 5'($urandom_range(0, HW_DEPTH));
		else
			return 5'($urandom_range(HW_DEPTH - 4, HW_DEPTH));
	endfunction

	function automatic logic [15:0] pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return 16'($urandom_range(1, 12));
		else if (r < 95)
			return 16'($urandom_range(13, 40));
		else
			return 16'($urandom_range(41, QDEPTH - 1));
	endfunction

	// result side: random stalls, every accepted transaction checked in order
	initial begin
		ftxq_pkg::out_item_t want;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					$error("result with nothing expected: kind %0d", result.kind);
					failures++;
				end else begin
					want = awaited_results.pop_front();
					if (result.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, result.kind);
						failures++;
					end
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						failures++;
					end
					if (result.tx_byte !== want.tx_byte) begin
						$error("tx_byte: expected %0h, got %0h", want.tx_byte, result.tx_byte);
						failures++;
					end
					if (result.irq_enable !== want.irq_enable) begin
						$error("irq_enable: expected %0b, got %0b",
							want.irq_enable, result.irq_enable);
						failures++;
					end
					if (result.drop_count !== want.drop_count) begin
						$error("drop_count: expected %0d, got %0d",
							want.drop_count, result.drop_count);
						failures++;
					end
					if (result.free_slots !== want.free_slots) begin
						$error("free_slots: expected %0d, got %0d",
							want.free_slots, result.free_slots);
						failures++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, result.last);
						failures++;
					end
					if (want.kind == ftxq_pkg::KIND_BYTE)
						bytes_drained++;
				end
			end
			result_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		ftxq_pkg::out_item_t typed_res;
		ftxq_pkg::in_item_t  it;
		int                  len;
		int                  sel;

		arst_n        <= 1'b0;
		item_valid    <= 1'b0;
		item          <= '0;
		failures      = 0;
		results_seen  = 0;
		handled_items = 0;
		bytes_drained = 0;
		refusals      = 0;
		gap_pct       = 0;
		stall_pct     = 0;
		rd_ptr        = 0;
		commit_ptr    = 0;
		work_ptr      = 0;
		frame_left    = 0;
		drop_total    = '0;

		// directed table: cmd, length, word, level, typed, kind, status, irq, drops, free
		// drain straight after reset finds nothing
		dir_rows[0]  = {ftxq_pkg::CMD_DRAIN, 16'd0, 16'd0, 5'd0, 1'b1,
			ftxq_pkg::KIND_DONE, ftxq_pkg::STAT_OK, 1'b0, 32'd0, 8'd0};
		// invalid lengths: zero, largest field value, exactly the depth
		dir_rows[1]  = {ftxq_pkg::CMD_OFFER, 16'd0, 16'd0, 5'd0, 1'b1,
			ftxq_pkg::KIND_OFFER, ftxq_pkg::STAT_BAD_LEN, 1'b0, 32'd0, 8'd0};
		dir_rows[2]  = {ftxq_pkg::CMD_OFFER, 16'hFFFF, 16'd0, 5'd0, 1'b1,
			ftxq_pkg::KIND_OFFER, ftxq_pkg::STAT_BAD_LEN, 1'b0, 32'd0, 8'd0};
		dir_rows[3]  = {ftxq_pkg::CMD_OFFER, 16'd256, 16'd0, 5'd0, 1'b1,
			ftxq_pkg::KIND_OFFER, ftxq_pkg::STAT_BAD_LEN, 1'b0, 32'd0, 8'd0};
		// word with no frame open, and the unknown command, both ignored
		dir_rows[4]  = {ftxq_pkg::CMD_WORD, 16'd0, 16'h1234, 5'd0, 1'b0,
			ftxq_pkg::KIND_OFFER, ftxq_pkg::STAT_OK, 1'b0, 32'd0, 8'd0};
		dir_rows[5]  = {CMD_UNKNOWN, 16'hFFFF, 16'hFFFF, 5'd16, 1'b0,
			ftxq_pkg::KIND_OFFER, ftxq_pkg::STAT_OK, 1'b0, 32'd0, 8'd0};
		// largest frame that fits an empty ring, then abandoned by a new offer
		dir_rows[6]  = {ftxq_pkg::CMD_OFFER, 16'd255, 16'd0, 5'd0, 1'b1,
			ftxq_pkg::KIND_OFFER, ftxq_pkg::STAT_OK, 1'b0, 32'd0, 8'd255};
		dir_rows[7]  = {ftxq_pkg::CMD_OFFER, 16'd1, 16'd0, 5'd0, 1'b1,
			ftxq_pkg::KIND_OFFER, ftxq_pkg::STAT_OK, 1'b0, 32'd0, 8'd255};
		// final byte with the hardware fifo full: no bytes move, data remains
		dir_rows[8]  = {ftxq_pkg::CMD_WORD, 16'd0, 16'hFFAB, 5'd16, 1'b1,
			ftxq_pkg::KIND_DONE, ftxq_pkg::STAT_OK, 1'b1, 32'd0, 8'd0};
		// not enough room bumps the drop counter
		dir_rows[9]  = {ftxq_pkg::CMD_OFFER, 16'd255, 16'd0, 5'd0, 1'b1,
			ftxq_pkg::KIND_OFFER, ftxq_pkg::STAT_NO_ROOM, 1'b0, 32'd1, 8'd254};
		dir_rows[10] = {ftxq_pkg::CMD_OFFER, 16'd254, 16'd0, 5'd0, 1'b1,
			ftxq_pkg::KIND_OFFER, ftxq_pkg::STAT_OK, 1'b0, 32'd1, 8'd254};
		// frame abandoned half way, its bytes must never appear
		dir_rows[11] = {ftxq_pkg::CMD_OFFER, 16'd3, 16'd0, 5'd0, 1'b1,
			ftxq_pkg::KIND_OFFER, ftxq_pkg::STAT_OK, 1'b0, 32'd1, 8'd254};
		dir_rows[12] = {ftxq_pkg::CMD_WORD, 16'd0, 16'h0000, 5'd0, 1'b0,
			ftxq_pkg::KIND_OFFER, ftxq_pkg::STAT_OK, 1'b0, 32'd0, 8'd0};
		dir_rows[13] = {ftxq_pkg::CMD_WORD, 16'd0, 16'hFFFF, 5'd0, 1'b0,
			ftxq_pkg::KIND_OFFER, ftxq_pkg::STAT_OK, 1'b0, 32'd0, 8'd0};
		dir_rows[14] = {ftxq_pkg::CMD_OFFER, 16'd2, 16'd0, 5'd0, 1'b1,
			ftxq_pkg::KIND_OFFER, ftxq_pkg::STAT_OK, 1'b0, 32'd1, 8'd254};
		dir_rows[15] = {ftxq_pkg::CMD_WORD, 16'd0, 16'h5A5A, 5'd0, 1'b0,
			ftxq_pkg::KIND_OFFER, ftxq_pkg::STAT_OK, 1'b0, 32'd0, 8'd0};
		// drain stops when the fifo level reaches the top
		dir_rows[16] = {ftxq_pkg::CMD_WORD, 16'd0, 16'hA5A5, 5'd15, 1'b0,
			ftxq_pkg::KIND_OFFER, ftxq_pkg::STAT_OK, 1'b0, 32'd0, 8'd0};
		dir_rows[17] = {ftxq_pkg::CMD_DRAIN, 16'd0, 16'd0, 5'd14, 1'b0,
			ftxq_pkg::KIND_OFFER, ftxq_pkg::STAT_OK, 1'b0, 32'd0, 8'd0};
		dir_rows[18] = {ftxq_pkg::CMD_DRAIN, 16'd0, 16'd0, 5'd16, 1'b1,
			ftxq_pkg::KIND_DONE, ftxq_pkg::STAT_OK, 1'b0, 32'd1, 8'd0};
		// empty ring with pointers away from zero, then a drain with a frame open
		dir_rows[19] = {ftxq_pkg::CMD_OFFER, 16'd255, 16'd0, 5'd0, 1'b1,
			ftxq_pkg::KIND_OFFER, ftxq_pkg::STAT_OK, 1'b0, 32'd1, 8'd255};
		dir_rows[20] = {ftxq_pkg::CMD_DRAIN, 16'd0, 16'd0, 5'd3, 1'b1,
			ftxq_pkg::KIND_DONE, ftxq_pkg::STAT_OK, 1'b0, 32'd1, 8'd0};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIR; i++) begin
			it.command      = dir_rows[i].cmd;
			it.frame_length = dir_rows[i].len;
			it.frame_word   = dir_rows[i].wrd;
			it.fifo_level   = dir_rows[i].lvl;
			typed_res            = '0;
			typed_res.kind       = dir_rows[i].e_kind;
			typed_res.status     = dir_rows[i].e_status;
			typed_res.irq_enable = dir_rows[i].e_irq;
			typed_res.drop_count = dir_rows[i].e_drops;
			typed_res.free_slots = dir_rows[i].e_free;
			typed_res.last       = 1'b1;
			send_transaction(it, dir_rows[i].typed, typed_res);
		end

		// random traffic: mostly whole frames, with aborts, stray words and bad offers
		while (handled_items < ITEMS) begin
			sel = $urandom_range(99);
			if (sel < 70) begin
				len = pick_length();
				send_cmd(ftxq_pkg::CMD_OFFER, 16'(len), 16'($urandom), pick_level());
				for (int w = 0; w < len; w++) begin
					if ($urandom_range(99) < 3)
						break;
					if ($urandom_range(99) < 5)
						send_cmd(ftxq_pkg::CMD_DRAIN, 16'($urandom), 16'($urandom),
							pick_level());
					send_cmd(ftxq_pkg::CMD_WORD, 16'($urandom), 16'($urandom),
						pick_level());
				end
				if ($urandom_range(99) < 40)
					send_cmd(ftxq_pkg::CMD_DRAIN, 16'($urandom), 16'($urandom),
						pick_level());
			end else if (sel < 80) begin
				send_cmd(ftxq_pkg::CMD_DRAIN, 16'($urandom), 16'($urandom), pick_level());
			end else if (sel < 88) begin
				if ($urandom_range(1) == 0)
					send_cmd(ftxq_pkg::CMD_OFFER, 16'd0, 16'($urandom), pick_level());
				else
					send_cmd(ftxq_pkg::CMD_OFFER, 16'($urandom_range(QDEPTH, 65535)),
						16'($urandom), pick_level());
			end else if (sel < 94) begin
				send_cmd(ftxq_pkg::CMD_WORD, 16'($urandom), 16'($urandom), pick_level());
			end else begin
				send_cmd(CMD_UNKNOWN, 16'($urandom), 16'($urandom), pick_level());
			end
		end

		item_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("%0d transactions handled, %0d results checked, %0d bytes drained",
			handled_items, results_seen, bytes_drained);
		$display("%0d offers refused for room, over four idling profiles", refusals);
		if (failures == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", failures);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+design
design/ftxq_pkg.sv
design/ftxq_ram.sv
design/ftxq_ctrl.sv
design/ftxq_dp.sv
design/frame_atomic_tx_ring_queue_unit.sv
design/ftxq_checker.sv
tb/sv/frame_atomic_tx_ring_queue_unit_test.sv
